FILE: sv/seg_pkg.sv
// ----------------------------------------------------------------------------
// seg_pkg
// Shared widths for the segment intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package seg_pkg;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DIFF_W    = 33;
  localparam int unsigned PROD_W    = 66;
  localparam int unsigned SUM_W     = 67;
  localparam int unsigned MAG_W     = 66;
  localparam int unsigned NUM_W     = 99;
  localparam int unsigned Q_W       = 33;
endpackage
`default_nettype wire

FILE: sv/seg_div.sv
// ----------------------------------------------------------------------------
// seg_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
`default_nettype none
module seg_div #(
  parameter int unsigned NW = 99,
  parameter int unsigned DW = 66,
  parameter int unsigned QW = 33,
  parameter int unsigned PW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [PW-1:0] in_pay,
  output logic               out_valid,
  output logic [QW-1:0]      out_quo,
  output logic [PW-1:0]      out_pay
);
  logic              v_r   [QW];
  logic [DW:0]       rem_r [QW];
  logic [NW-1:0]     num_r [QW];
  logic [DW-1:0]     den_r [QW];
  logic [QW-1:0]     quo_r [QW];
  logic [PW-1:0]     pay_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic          v_p;
    logic [DW:0]   rem_p;
    logic [NW-1:0] num_p;
    logic [DW-1:0] den_p;
    logic [QW-1:0] quo_p;
    logic [PW-1:0] pay_p;
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    if (s == 0) begin : g_in
      assign v_p   = in_valid;
      assign rem_p = (DW+1)'(in_num[NW-1:QW]);
      assign num_p = in_num;
      assign den_p = in_den;
      assign quo_p = '0;
      assign pay_p = in_pay;
    end else begin : g_pr
      assign v_p   = v_r[s-1];
      assign rem_p = rem_r[s-1];
      assign num_p = num_r[s-1];
      assign den_p = den_r[s-1];
      assign quo_p = quo_r[s-1];
      assign pay_p = pay_r[s-1];
    end
    always_comb begin
      sh = {rem_p, num_p[QW-1-s]};
      df = sh - {2'b00, den_p};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_p;
      end
      if (en) begin
        rem_r[s] <= df[DW+1] ? sh[DW:0] : df[DW:0];
        quo_r[s] <= {quo_p[QW-2:0], ~df[DW+1]};
        num_r[s] <= num_p;
        den_r[s] <= den_p;
        pay_r[s] <= pay_p;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_pay   = pay_r[QW-1];
endmodule
`default_nettype wire

FILE: sv/segment_intersection_2d.sv
// ----------------------------------------------------------------------------
// segment_intersection_2d
// Segment pair intersection in the x-z plane, signed Q16.16.
// ----------------------------------------------------------------------------
// One segment pair is taken every cycle while the pipe advances; its result
// passes the difference, product, sum, magnitude and two scaling stages, then
// the two bit-per-stage quotient pipelines (33 stages, side by side) and the
// output register. The whole pipe advances when the output register is empty
// or being read, so a stall holds every stage.
`default_nettype none
module segment_intersection_2d (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // a_start_x, a_start_z, a_start_height, a_end_x, a_end_z,
  // b_start_x, b_start_z, b_end_x, b_end_z
  input  wire logic [287:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // cross_x, cross_z, cross_height
  output logic [95:0]       out_tdata,
  // hit
  output logic              out_tuser
);
  import seg_pkg::*;

  typedef logic signed [COORD_W-1:0] crd_t;
  typedef logic signed [DIFF_W-1:0]  dif_t;
  typedef logic signed [PROD_W-1:0]  prd_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  logic en;
  logic ov_r;
  assign en        = !ov_r || out_tready;
  assign in_tready = en;

  crd_t asx, asz, ah, aex, aez, bsx, bsz, bex, bez;
  assign asx = in_tdata[31:0];
  assign asz = in_tdata[63:32];
  assign ah  = in_tdata[95:64];
  assign aex = in_tdata[127:96];
  assign aez = in_tdata[159:128];
  assign bsx = in_tdata[191:160];
  assign bsz = in_tdata[223:192];
  assign bex = in_tdata[255:224];
  assign bez = in_tdata[287:256];

  // stage 1: differences
  logic v1_r;
  dif_t dbx_r, daz_r, dax_r, dbz_r, dzb_r, dsx_r, dsz_r, ex_r, ez_r;
  crd_t s1x_r, s1z_r, h1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
    if (en) begin
      dbx_r <= DIFF_W'(bex) - DIFF_W'(bsx);
      daz_r <= DIFF_W'(asz) - DIFF_W'(aez);
      dax_r <= DIFF_W'(asx) - DIFF_W'(aex);
      dbz_r <= DIFF_W'(bez) - DIFF_W'(bsz);
      dzb_r <= DIFF_W'(bsz) - DIFF_W'(bez);
      dsx_r <= DIFF_W'(asx) - DIFF_W'(bsx);
      dsz_r <= DIFF_W'(asz) - DIFF_W'(bsz);
      ex_r  <= DIFF_W'(aex) - DIFF_W'(asx);
      ez_r  <= DIFF_W'(aez) - DIFF_W'(asz);
      s1x_r <= asx; s1z_r <= asz; h1_r <= ah;
    end
  end

  // stage 2: products
  logic v2_r;
  prd_t p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  dif_t ex2_r, ez2_r;
  crd_t s2x_r, s2z_r, h2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      p0_r <= PROD_W'(dbx_r) * PROD_W'(daz_r);
      p1_r <= PROD_W'(dax_r) * PROD_W'(dbz_r);
      p2_r <= PROD_W'(dzb_r) * PROD_W'(dsx_r);
      p3_r <= PROD_W'(dbx_r) * PROD_W'(dsz_r);
      p4_r <= PROD_W'(daz_r) * PROD_W'(dsx_r);
      p5_r <= PROD_W'(ex_r) * PROD_W'(dsz_r);
      ex2_r <= ex_r; ez2_r <= ez_r;
      s2x_r <= s1x_r; s2z_r <= s1z_r; h2_r <= h1_r;
    end
  end

  // stage 3: sums
  logic v3_r;
  sum_t d_r, n1_r, n2_r;
  dif_t ex3_r, ez3_r;
  crd_t s3x_r, s3z_r, h3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      d_r  <= SUM_W'(p0_r) - SUM_W'(p1_r);
      n1_r <= SUM_W'(p2_r) + SUM_W'(p3_r);
      n2_r <= SUM_W'(p4_r) + SUM_W'(p5_r);
      ex3_r <= ex2_r; ez3_r <= ez2_r;
      s3x_r <= s2x_r; s3z_r <= s2z_r; h3_r <= h2_r;
    end
  end

  // stage 4: magnitudes and hit test
  logic [MAG_W-1:0] ad, an1, an2;
  logic hit_c;
  always_comb begin
    ad  = MAG_W'(d_r[SUM_W-1] ? -d_r : d_r);
    an1 = MAG_W'(n1_r[SUM_W-1] ? -n1_r : n1_r);
    an2 = MAG_W'(n2_r[SUM_W-1] ? -n2_r : n2_r);
    hit_c = (d_r != '0) && (n1_r != '0) && (n2_r != '0)
         && (n1_r[SUM_W-1] == d_r[SUM_W-1]) && (n2_r[SUM_W-1] == d_r[SUM_W-1])
         && (an1 <= ad) && (an2 <= ad);
  end

  logic v4_r, hit4_r, sgx4_r, sgz4_r;
  logic [MAG_W-1:0] ad4_r, an4_r;
  logic [DIFF_W-2:0] mx4_r, mz4_r;
  crd_t s4x_r, s4z_r, h4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
    if (en) begin
      hit4_r <= hit_c;
      ad4_r  <= hit_c ? ad : MAG_W'(1);
      an4_r  <= an1;
      mx4_r  <= (DIFF_W-1)'(ex3_r[DIFF_W-1] ? -ex3_r : ex3_r);
      mz4_r  <= (DIFF_W-1)'(ez3_r[DIFF_W-1] ? -ez3_r : ez3_r);
      sgx4_r <= ex3_r[DIFF_W-1];
      sgz4_r <= ez3_r[DIFF_W-1];
      s4x_r <= s3x_r; s4z_r <= s3z_r; h4_r <= h3_r;
    end
  end

  // stage 5: partial products of the scaled numerators, split in halves
  localparam int unsigned HALF_W = MAG_W / 2;
  localparam int unsigned PP_W   = HALF_W + DIFF_W - 1;
  logic v5_r, hit5_r, sgx5_r, sgz5_r;
  logic [PP_W-1:0] lx5_r, hx5_r, lz5_r, hz5_r;
  logic [MAG_W-1:0] ad5_r;
  crd_t s5x_r, s5z_r, h5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
    if (en) begin
      lx5_r <= PP_W'(an4_r[HALF_W-1:0]) * PP_W'(mx4_r);
      hx5_r <= PP_W'(an4_r[MAG_W-1:HALF_W]) * PP_W'(mx4_r);
      lz5_r <= PP_W'(an4_r[HALF_W-1:0]) * PP_W'(mz4_r);
      hz5_r <= PP_W'(an4_r[MAG_W-1:HALF_W]) * PP_W'(mz4_r);
      ad5_r <= ad4_r;
      hit5_r <= hit4_r; sgx5_r <= sgx4_r; sgz5_r <= sgz4_r;
      s5x_r <= s4x_r; s5z_r <= s4z_r; h5_r <= h4_r;
    end
  end

  // stage 6: scaled numerators (an1 <= ad on a hit, so 66 x 32 bits suffice)
  logic v6_r, hit6_r, sgx6_r, sgz6_r;
  logic [NUM_W-1:0] nx6_r, nz6_r;
  logic [MAG_W-1:0] ad6_r;
  crd_t s6x_r, s6z_r, h6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
    if (en) begin
      nx6_r <= (NUM_W'(hx5_r) << HALF_W) + NUM_W'(lx5_r);
      nz6_r <= (NUM_W'(hz5_r) << HALF_W) + NUM_W'(lz5_r);
      ad6_r <= ad5_r;
      hit6_r <= hit5_r; sgx6_r <= sgx5_r; sgz6_r <= sgz5_r;
      s6x_r <= s5x_r; s6z_r <= s5z_r; h6_r <= h5_r;
    end
  end

  localparam int unsigned PAYX_W = 2 + 2 * COORD_W;
  localparam int unsigned PAYZ_W = 1 + COORD_W;
  logic [PAYX_W-1:0] pay6x, payx;
  logic [PAYZ_W-1:0] pay6z, payz;
  logic [Q_W-1:0] qx, qz;
  logic vx, vz;
  assign pay6x = {hit6_r, sgx6_r, h6_r, s6x_r};
  assign pay6z = {sgz6_r, s6z_r};

  seg_div #(.NW(NUM_W), .DW(MAG_W), .QW(Q_W), .PW(PAYX_W)) u_div_x (
    .clk, .rst_n, .en, .in_valid(v6_r), .in_num(nx6_r), .in_den(ad6_r),
    .in_pay(pay6x), .out_valid(vx), .out_quo(qx), .out_pay(payx)
  );
  seg_div #(.NW(NUM_W), .DW(MAG_W), .QW(Q_W), .PW(PAYZ_W)) u_div_z (
    .clk, .rst_n, .en, .in_valid(v6_r), .in_num(nz6_r), .in_den(ad6_r),
    .in_pay(pay6z), .out_valid(vz), .out_quo(qz), .out_pay(payz)
  );

  // output register
  logic hitd, sgx, sgz;
  crd_t sx, sz, hd, qxs, qzs;
  always_comb begin
    hitd = payx[PAYX_W-1];
    sgx  = payx[PAYX_W-2];
    hd   = payx[2*COORD_W-1:COORD_W];
    sx   = payx[COORD_W-1:0];
    sgz  = payz[PAYZ_W-1];
    sz   = payz[COORD_W-1:0];
    qxs  = sgx ? -qx[COORD_W-1:0] : qx[COORD_W-1:0];
    qzs  = sgz ? -qz[COORD_W-1:0] : qz[COORD_W-1:0];
  end

  logic hit_r;
  crd_t cx_r, cz_r, ch_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= vx & vz;
    if (en) begin
      hit_r <= hitd;
      cx_r  <= hitd ? sx + qxs : '0;
      cz_r  <= hitd ? sz + qzs : '0;
      ch_r  <= hitd ? hd : '0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = hit_r;
  assign out_tdata  = {ch_r, cz_r, cx_r};
endmodule
`default_nettype wire

FILE: dv/segment_intersection_2d_test.sv
// ----------------------------------------------------------------------------
// segment_intersection_2d_test
// Streams segment pairs through the intersection block and checks every
// result against an exact 128-bit prediction, under random gaps, stalls,
// a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
`default_nettype none
module segment_intersection_2d_test;
  import seg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t bez, bex, bsz, bsx, aez, aex, ash, asz, asx;
  } pair_t;

  typedef struct packed {
    logic   hit;
    coord_t cx, cz, ch;
  } cross_t;

  class cross_board;
    cross_t due[$];
    int     errors = 0;

    function automatic wide_t wx(coord_t v);
      return wide_t'(v);
    endfunction

    function automatic wide_t wabs(wide_t v);
      return v < 0 ? -v : v;
    endfunction

    function automatic bit in_unit(wide_t n, wide_t d);
      if (n == 0 || ((n < 0) != (d < 0))) return 0;
      return wabs(n) <= wabs(d);
    endfunction

    function automatic coord_t lerp(coord_t s, wide_t delta, wide_t n, wide_t d);
      logic [127:0] q;
      logic [127:0] r;
      bit neg;
      q = unsigned'(wabs(n)) * unsigned'(wabs(delta));
      q = q / unsigned'(wabs(d));
      neg = (delta < 0) != ((n < 0) != (d < 0));
      r = unsigned'(wx(s)) + (neg ? -q : q);
      return r[31:0];
    endfunction

    task automatic note(pair_t p);
      wide_t d, n1, n2;
      cross_t c;
      d  = (wx(p.bex) - wx(p.bsx)) * (wx(p.asz) - wx(p.aez))
         - (wx(p.asx) - wx(p.aex)) * (wx(p.bez) - wx(p.bsz));
      n1 = (wx(p.bsz) - wx(p.bez)) * (wx(p.asx) - wx(p.bsx))
         + (wx(p.bex) - wx(p.bsx)) * (wx(p.asz) - wx(p.bsz));
      n2 = (wx(p.asz) - wx(p.aez)) * (wx(p.asx) - wx(p.bsx))
         + (wx(p.aex) - wx(p.asx)) * (wx(p.asz) - wx(p.bsz));
      c = '0;
      if (d != 0 && in_unit(n1, d) && in_unit(n2, d)) begin
        c.hit = 1'b1;
        c.cx  = lerp(p.asx, wx(p.aex) - wx(p.asx), n1, d);
        c.cz  = lerp(p.asz, wx(p.aez) - wx(p.asz), n1, d);
        c.ch  = p.ash;
      end
      due = {due, c};
    endtask

    task automatic report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task automatic check(cross_t got);
      cross_t e;
      if (due.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      e = due.pop_front();
      if (got.hit != e.hit) report($sformatf("hit %0d want %0d", got.hit, e.hit));
      if (got.cx != e.cx) report($sformatf("cross_x %h want %h", got.cx, e.cx));
      if (got.cz != e.cz) report($sformatf("cross_z %h want %h", got.cz, e.cz));
      if (got.ch != e.ch) report($sformatf("cross_height %h want %h", got.ch, e.ch));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic         out_tuser;

  cross_board sb = new();
  int  cycles = 0;
  bit  hold_req = 0;
  localparam int LIMIT = 400000;

  segment_intersection_2d dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [287:0] pack(pair_t p);
    return {p.bez, p.bex, p.bsz, p.bsx, p.aez, p.aex, p.ash, p.asz, p.asx};
  endfunction

  function automatic pair_t mk(int asx, int asz, int ash, int aex, int aez,
                               int bsx, int bsz, int bex, int bez);
    pair_t p;
    p.asx = asx; p.asz = asz; p.ash = ash; p.aex = aex; p.aez = aez;
    p.bsx = bsx; p.bsz = bsz; p.bex = bex; p.bez = bez;
    return p;
  endfunction

  function automatic coord_t pick_wide();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic coord_t pick_near(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic send(pair_t p, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack(p);
    do @(posedge clk); while (!in_tready);
    sb.note(p);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int stall;
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check('{out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[95:64]});
    end
  end

  initial begin
    pair_t p;
    int span, gap;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // parallel, degenerate, start and end touches, plain crossing, extremes
    send(mk(0, 0, 5, 0, 0, 0, 0, 0, 0), 0);
    send(mk(0, 0, 7, 100, 0, 0, 10, 100, 10), 0);
    send(mk(0, 0, 9, 10, 0, 0, -5, 0, 5), 0);
    send(mk(0, 0, 9, 10, 0, 10, -5, 10, 5), 0);
    send(mk(0, 0, 9, 10, 0, 5, 0, 5, 5), 0);
    send(mk(0, 0, 9, 10, 0, 5, -5, 5, 0), 0);
    send(mk(-65536, -65536, 32'h1234_5678, 65536, 65536, -65536, 65536, 65536, -65536), 0);
    send(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000), 0);
    send(mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000), 3);
    send(mk(32'h7fff_ffff, 0, -1, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 32'h8000_0000), 0);
    send(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1), 0);
    send(mk(0, 0, 1, 300, 100, 100, 0, 200, 300), 0);
    send(mk(0, 0, 1, -300, -100, -100, 0, -200, -300), 0);
    drain();

    for (int i = 0; i < 800; i++) begin
      if (i == 300) hold_req = 1;
      if (i == 500) drain();
      if ($urandom_range(0, 4) == 0) begin
        p.asx = pick_wide(); p.asz = pick_wide(); p.ash = $urandom;
        p.aex = pick_wide(); p.aez = pick_wide();
        p.bsx = pick_wide(); p.bsz = pick_wide();
        p.bex = pick_wide(); p.bez = pick_wide();
      end else begin
        span = ($urandom_range(0, 3) == 0) ? 32'h3fff_ffff : $urandom_range(8, 1 << 20);
        p.asx = pick_near(span); p.asz = pick_near(span); p.ash = $urandom;
        p.aex = pick_near(span); p.aez = pick_near(span);
        p.bsx = pick_near(span); p.bsz = pick_near(span);
        p.bex = pick_near(span); p.bez = pick_near(span);
        if ($urandom_range(0, 7) == 0) begin
          p.bex = p.aex; p.bez = p.aez;
        end
      end
      gap = (i >= 300 && i < 360) ? 0
          : ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      send(p, gap);
    end
    drain();

    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
